FILE: rtl/spq_pkg.sv
// shared types and constants for the stable priority queue
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int SEV_W    = 8;
	localparam int PAY_W    = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TOTAL_W  = 5;
	localparam int STAT_W   = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [SEV_W-1:0] sev;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   del;
		entry_t ent;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/spq_req_if.sv
// request channel of the stable priority queue
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if import spq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [SEV_W-1:0] severity;
	logic [PAY_W-1:0] patient_id;

	modport source (output valid, cmd, severity, patient_id, input ready);
	modport sink   (input valid, cmd, severity, patient_id, output ready);
endinterface
`default_nettype wire

FILE: rtl/spq_rsp_if.sv
// response channel of the stable priority queue
`timescale 1ns / 1ps
`default_nettype none
interface spq_rsp_if import spq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [7:0]         head_severity;
	logic [15:0]        head_patient;
	logic               is_empty;
	logic [TOTAL_W-1:0] entry_total;
	logic [STAT_W-1:0]  status;

	modport source (output valid, head_severity, head_patient, is_empty, entry_total, status,
		input ready);
	modport sink   (input valid, head_severity, head_patient, is_empty, entry_total, status,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/stable_priority_queue_top.sv
// top level: cell chain, entry count and registered response
// the response is registered and shows in the cycle after a request is accepted
// throughput: one request per cycle while the response is taken
// the whole cell chain updates in the cycle a request is accepted
// reset clears the entry count and the response valid; slot contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue_top import spq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic [CNT_W-1:0]   count_q, count_d;
	logic               accept;
	logic               full, empty;
	cell_ctl_t          ctl;
	logic [STAT_W-1:0]  status_d;
	logic [CAPACITY:0]  keep_chain;
	entry_t             cell_data [CAPACITY+1];
	entry_t             cell_nxt  [CAPACITY];
	logic [31:0]        cnt_ext;
	logic               rsp_valid_q;
	logic [7:0]         head_sev_q;
	logic [15:0]        head_pay_q;
	logic               is_empty_q;
	logic [TOTAL_W-1:0] total_q;
	logic [STAT_W-1:0]  status_q;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign ctl.ins     = accept && (req.cmd == CMD_ENQ) && !full;
	assign ctl.del     = accept && (req.cmd == CMD_DEQ) && !empty;
	assign ctl.ent.sev = req.severity;
	assign ctl.ent.pay = req.patient_id;

	always_comb begin
		count_d  = count_q;
		status_d = ST_DONE;
		if (accept) begin
			if (req.cmd == CMD_ENQ) begin
				if (full) status_d = ST_FULL;
				else count_d = count_q + CNT_W'(1);
			end else begin
				if (empty) status_d = ST_EMPTY;
				else count_d = count_q - CNT_W'(1);
			end
		end
	end

	assign keep_chain[0]       = 1'b1;
	assign cell_data[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_W'(i) < count_q),
			.prev_keep (keep_chain[i]),
			.prev_data ((i == 0) ? ctl.ent : cell_data[(i == 0) ? 0 : i - 1]),
			.next_data (cell_data[i + 1]),
			.keep      (keep_chain[i + 1]),
			.data      (cell_data[i]),
			.data_nxt  (cell_nxt[i])
		);
	end

	assign cnt_ext = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_sev_q <= (count_d == '0) ? '0 : cell_nxt[0].sev;
			head_pay_q <= (count_d == '0) ? '0 : cell_nxt[0].pay;
			is_empty_q <= (count_d == '0);
			total_q    <= cnt_ext[TOTAL_W-1:0];
			status_q   <= status_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.head_severity = head_sev_q;
	assign rsp.head_patient  = head_pay_q;
	assign rsp.is_empty      = is_empty_q;
	assign rsp.entry_total   = total_q;
	assign rsp.status        = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_ENQ) && full |=> (rsp.status == ST_FULL) && $stable(count_q))
		else $error("enqueue into full queue not dropped");

	a_rsp_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid && (32'(rsp.entry_total) == 32'(count_q)))
		else $error("response missing or count mismatch");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (rsp.entry_total == '0)))
		else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

FILE: rtl/spq_cell.sv
// one slot of the sorted chain: keeps, takes the new entry or shifts from a neighbor
`timescale 1ns / 1ps
`default_nettype none
module spq_cell import spq_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occupied,
	input  wire logic      prev_keep,
	input  wire entry_t    prev_data,
	input  wire entry_t    next_data,
	output logic           keep,
	output entry_t         data,
	output entry_t         data_nxt
);

	entry_t data_q;

	assign keep = occupied && (data_q.sev >= ctl.ent.sev);
	assign data = data_q;

	always_comb begin
		data_nxt = data_q;
		if (ctl.ins) begin
			if (!keep) begin
				data_nxt = prev_keep ? ctl.ent : prev_data;
			end
		end else if (ctl.del) begin
			data_nxt = next_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule
`default_nettype wire

FILE: tb/stable_priority_queue_top_tb.sv
// self-checking testbench for the stable priority queue top level
`timescale 1ns / 1ps
module stable_priority_queue_top_tb import spq_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int SETTLE_CYCLES  = 4;

	localparam logic [SEV_W-1:0] FILL_SEV [CAPACITY] = '{
		8'd0, 8'd255, 8'd7, 8'd255, 8'd7, 8'd0, 8'd128, 8'd1,
		8'd254, 8'd7, 8'd128, 8'd0, 8'd255, 8'd64, 8'd7, 8'd200
	};

	typedef struct packed {
		logic [7:0]         head_sev;
		logic [15:0]        head_pay;
		logic               empty;
		logic [TOTAL_W-1:0] total;
		logic [STAT_W-1:0]  status;
	} queue_view_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	stable_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// queue state as the block should hold it
	logic [SEV_W-1:0] model_sev [CAPACITY];
	logic [PAY_W-1:0] model_pay [CAPACITY];
	int               model_held = 0;

	queue_view_t expected_views [$];
	int          mismatch_count = 0;
	int          sender_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          quiet_cycles = 0;

	function automatic void apply_to_model(input logic cmd, input logic [SEV_W-1:0] sev,
		input logic [PAY_W-1:0] pay);
		queue_view_t view;
		int          pos;
		view.status = ST_DONE;
		if (cmd == CMD_ENQ) begin
			if (model_held >= CAPACITY) begin
				view.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < model_held && model_sev[pos] >= sev)
					pos++;
				for (int i = model_held; i > pos; i--) begin
					model_sev[i] = model_sev[i-1];
					model_pay[i] = model_pay[i-1];
				end
				model_sev[pos] = sev;
				model_pay[pos] = pay;
				model_held++;
			end
		end else begin
			if (model_held == 0) begin
				view.status = ST_EMPTY;
			end else begin
				for (int i = 1; i < model_held; i++) begin
					model_sev[i-1] = model_sev[i];
					model_pay[i-1] = model_pay[i];
				end
				model_held--;
			end
		end
		if (model_held > 0) begin
			view.head_sev = model_sev[0];
			view.head_pay = model_pay[0];
			view.empty    = 1'b0;
		end else begin
			view.head_sev = '0;
			view.head_pay = '0;
			view.empty    = 1'b1;
		end
		view.total = model_held[TOTAL_W-1:0];
		expected_views.push_back(view);
	endfunction

	task automatic send_request(input logic cmd, input logic [SEV_W-1:0] sev,
		input logic [PAY_W-1:0] pay);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.severity   <= sev;
		req_ch.patient_id <= pay;
		do @(posedge clk); while (!req_ch.ready);
		apply_to_model(cmd, sev, pay);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_dequeue();
		send_request(CMD_DEQ, 8'($urandom), 16'($urandom));
	endtask

	task automatic test_fill_to_capacity();
		logic [PAY_W-1:0] pay;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0)
				pay = '0;
			else if (i == 1)
				pay = '1;
			else
				pay = 16'($urandom);
			send_request(CMD_ENQ, FILL_SEV[i], pay);
		end
	endtask

	task automatic test_overflow_drop();
		send_request(CMD_ENQ, 8'd255, 16'hffff);
		send_request(CMD_ENQ, 8'd0, 16'h0000);
	endtask

	task automatic test_head_removal();
		repeat (3) send_request(CMD_DEQ, 8'($urandom), 16'($urandom));
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		int               enq_bias;
		logic             cmd;
		logic [SEV_W-1:0] sev;
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		enq_bias        = 50;
		for (int i = 0; i < count; i++) begin
			// swing between filling and draining so both full and empty are reached
			if (i % 30 == 0) begin
				case ($urandom_range(3))
					0: enq_bias = 85;
					1: enq_bias = 15;
					2: enq_bias = 60;
					default: enq_bias = 45;
				endcase
			end
			cmd = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
			case ($urandom_range(3))
				0: sev = 8'($urandom_range(3));
				1: sev = $urandom_range(1) ? 8'd255 : 8'd0;
				default: sev = 8'($urandom_range(255));
			endcase
			send_request(cmd, sev, 16'($urandom_range(16'hffff)));
		end
		hold_until_drained();
	endtask

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		queue_view_t got;
		queue_view_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.head_severity, rsp_ch.head_patient, rsp_ch.is_empty,
				rsp_ch.entry_total, rsp_ch.status};
			if (expected_views.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected response: sev %0d pat %0d empty %0b total %0d status %0d",
						got.head_sev, got.head_pay, got.empty, got.total, got.status);
			end else begin
				want = expected_views.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"mismatch: expected sev %0d pat %0d empty %0b total %0d status %0d,",
							" got sev %0d pat %0d empty %0b total %0d status %0d"},
							want.head_sev, want.head_pay, want.empty, want.total, want.status,
							got.head_sev, got.head_pay, got.empty, got.total, got.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_ENQ;
		req_ch.severity   = '0;
		req_ch.patient_id = '0;
		rsp_ch.ready      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_dequeue();
		test_fill_to_capacity();
		test_overflow_drop();
		test_head_removal();
		hold_until_drained();

		test_random_traffic(115, 0, 0);
		test_random_traffic(115, 70, 0);
		test_random_traffic(115, 0, 70);
		test_random_traffic(115, 36, 36);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_views.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_top.sv
tb/stable_priority_queue_top_tb.sv
